/* rtl/iptr_pkg.sv */
`default_nettype none
package iptr_pkg;

  localparam int LABEL_W = 7;
  localparam int LABEL_N = 1 << LABEL_W;
  localparam int MAX_NODES_DEF = 128;

  // tdata widths rounded up to whole bytes
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 16;

  // update request for the has-left-child bits
  typedef struct packed {
    logic               clear;
    logic               set;
    logic [LABEL_W-1:0] idx;
  } lb_ctrl_t;

endpackage
`default_nettype wire

/* rtl/iptr_left_bits.sv */
`default_nettype none
module iptr_left_bits (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire iptr_pkg::lb_ctrl_t          ctrl,
  input  wire logic [iptr_pkg::LABEL_W-1:0] label,
  output logic                             succ_has_left
);

  logic [iptr_pkg::LABEL_N-1:0] bits;
  logic [iptr_pkg::LABEL_W-1:0] succ;
  logic                         succ_in_range;

  assign succ          = label + iptr_pkg::LABEL_W'(1);
  assign succ_in_range = (label != iptr_pkg::LABEL_W'(iptr_pkg::LABEL_N - 1));

  // a mark made by the same transaction counts already
  assign succ_has_left = succ_in_range &&
                         (bits[succ] || (ctrl.set && ctrl.idx == succ));

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else if (ctrl.clear) begin
      bits <= '0;
    end else if (ctrl.set) begin
      bits[ctrl.idx] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/iptr_stack.sv */
`default_nettype none
module iptr_stack #(
  parameter int MAX_NODES = iptr_pkg::MAX_NODES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               push,
  input  wire logic [$clog2(MAX_NODES)-1:0]       wr_addr,
  input  wire logic [iptr_pkg::LABEL_W-1:0]        wr_data,
  input  wire logic [$clog2(MAX_NODES)-1:0]       rd_addr,
  output logic      [iptr_pkg::LABEL_W-1:0]        top
);

  logic [iptr_pkg::LABEL_W-1:0] mem [MAX_NODES];
  logic [iptr_pkg::LABEL_W-1:0] rdata;
  logic                         byp;
  logic [iptr_pkg::LABEL_W-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (en && push) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // prefetch the entry that becomes the top after this transaction
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[rd_addr];
    end
  end

  // a push lands on the new top: serve it from the bypass register
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (en) begin
      byp <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (en && push) begin
      byp_data <= wr_data;
    end
  end

  assign top = byp ? byp_data : rdata;

endmodule
`default_nettype wire

/* rtl/inorder_preorder_tree_rebuild_top.sv */
// Rebuilds a binary tree from labels given in preorder, each label being the
// node's inorder position. The first label of a sequence (after reset or after
// a label with tlast set) is the root and gives no output; every later label
// gives one graft: parent, child and side, or an error flag on stack underflow
// or overflow. Throughput is one label per clock cycle unless the output
// register is full and m_tready is low; a label passes the input register,
// then the result register. The label stack is a single-port-write memory
// with a registered read of the next top-of-stack, plus a bypass for the last
// push, so a pop never waits on the memory. The has-left-child bits are
// flip-flops and all clear at once when a root arrives.
`default_nettype none
module inorder_preorder_tree_rebuild_top #(
  parameter int MAX_NODES = iptr_pkg::MAX_NODES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [iptr_pkg::S_DATA_W-1:0] s_tdata,  // [6:0] label
  input  wire logic                          s_tlast,  // is_last
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [iptr_pkg::M_DATA_W-1:0] m_tdata,  // [6:0] parent, [13:7] child, [14] is_right
  output logic                               m_tuser,  // error
  output logic                               m_tlast   // seq_end
);

  localparam int ADDR_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int LW     = iptr_pkg::LABEL_W;

  // input register
  logic          in_valid;
  logic [LW-1:0] in_label;
  logic          in_last;

  // tree state
  logic [LW-1:0]    prev_label;
  logic             awaiting_root;
  logic [CNT_W-1:0] stack_count;

  // output register
  logic          out_valid;
  logic [LW-1:0] out_parent;
  logic [LW-1:0] out_child;
  logic          out_right;
  logic          out_error;
  logic          out_last;

  logic               advance;
  logic               go_left;
  logic               do_pop;
  logic               underflow;
  logic               overflow;
  logic               want_push;
  logic               do_push;
  logic               succ_has_left;
  logic               prev_in_range;
  logic               err;
  logic [CNT_W-1:0]   cnt_mid;
  logic [CNT_W-1:0]   stack_count_next;
  logic [CNT_W-1:0]   rd_cnt;
  logic [LW-1:0]      stack_top;
  logic [LW-1:0]      parent;
  iptr_pkg::lb_ctrl_t lb_ctrl;

  // a root needs no output slot
  assign advance  = in_valid && (awaiting_root || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign go_left       = (prev_label > in_label);
  assign do_pop        = !go_left && (stack_count != '0);
  assign underflow     = !go_left && (stack_count == '0);
  assign cnt_mid       = stack_count - CNT_W'(do_pop);
  assign prev_in_range = (32'(prev_label) <= 32'(MAX_NODES));
  assign want_push     = !succ_has_left;
  assign overflow      = want_push && (cnt_mid >= CNT_W'(MAX_NODES));
  assign do_push       = awaiting_root || (want_push && !overflow);
  assign err           = underflow || overflow;
  assign parent        = go_left ? prev_label : stack_top;

  always_comb begin
    if (awaiting_root) begin
      stack_count_next = CNT_W'(1);
    end else begin
      stack_count_next = cnt_mid + CNT_W'(do_push);
    end
  end

  assign rd_cnt = stack_count_next - CNT_W'(1);

  always_comb begin
    lb_ctrl.clear = advance && awaiting_root;
    lb_ctrl.set   = advance && !awaiting_root && go_left && prev_in_range;
    lb_ctrl.idx   = prev_label;
  end

  iptr_left_bits u_left_bits (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (lb_ctrl),
    .label         (in_label),
    .succ_has_left (succ_has_left)
  );

  iptr_stack #(
    .MAX_NODES (MAX_NODES)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .push    (do_push),
    .wr_addr (awaiting_root ? ADDR_W'(0) : cnt_mid[ADDR_W-1:0]),
    .wr_data (in_label),
    .rd_addr (rd_cnt[ADDR_W-1:0]),
    .top     (stack_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_label <= s_tdata[LW-1:0];
      in_last  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_label    <= '0;
      awaiting_root <= 1'b1;
      stack_count   <= '0;
    end else if (advance) begin
      prev_label    <= in_label;
      awaiting_root <= in_last;
      stack_count   <= stack_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && !awaiting_root) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // zero the graft fields on error
  always_ff @(posedge clk) begin
    if (advance && !awaiting_root) begin
      out_parent <= err ? '0 : parent;
      out_child  <= err ? '0 : in_label;
      out_right  <= !err && !go_left;
      out_error  <= err;
      out_last   <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_right, out_child, out_parent};
  assign m_tuser  = out_error;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

/* verif/tree_graft_checker.sv */
module tree_graft_checker #(
  parameter int MAX_NODES = iptr_pkg::MAX_NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [iptr_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [iptr_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          m_tuser,
  input  logic                          m_tlast,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LB_IDX_W  = $clog2(MAX_NODES + 1);
  localparam int STK_IDX_W = $clog2(MAX_NODES);

  typedef struct packed {
    logic [iptr_pkg::LABEL_W-1:0] parent;
    logic [iptr_pkg::LABEL_W-1:0] child;
    logic                         is_right;
    logic                         error;
    logic                         seq_end;
  } graft_t;

  graft_t                       expected_grafts[$];
  logic [iptr_pkg::LABEL_W-1:0] last_label;
  logic                         want_root;
  logic                         left_child [0:MAX_NODES];
  logic [iptr_pkg::LABEL_W-1:0] node_stack [0:MAX_NODES-1];
  int                           depth;

  // Returns 1 when the label produces a graft.
  function automatic bit rebuild_step(input logic [iptr_pkg::LABEL_W-1:0] lbl,
                                      input logic last, output graft_t g);
    int  succ;
    bit  succ_has_left;
    g          = '0;
    g.child    = lbl;
    g.seq_end  = last;
    if (want_root) begin
      for (int i = 0; i <= MAX_NODES; i++) left_child[LB_IDX_W'(i)] = 1'b0;
      node_stack[0] = lbl;
      depth         = 1;
      last_label    = lbl;
      want_root     = last;
      return 1'b0;
    end
    if (last_label > lbl) begin
      g.parent   = last_label;
      g.is_right = 1'b0;
      if (int'(last_label) <= MAX_NODES) left_child[LB_IDX_W'(last_label)] = 1'b1;
    end else if (depth == 0) begin
      g.error = 1'b1;
    end else begin
      depth--;
      g.parent   = node_stack[STK_IDX_W'(depth)];
      g.is_right = 1'b1;
    end
    // successor beyond the table acts like the virtual label: no left child
    succ          = int'(lbl) + 1;
    succ_has_left = 1'b0;
    if (succ <= MAX_NODES) succ_has_left = left_child[LB_IDX_W'(succ)];
    if (!succ_has_left) begin
      if (depth >= MAX_NODES) begin
        g.error = 1'b1;
      end else begin
        node_stack[STK_IDX_W'(depth)] = lbl;
        depth++;
      end
    end
    last_label = lbl;
    want_root  = last;
    if (g.error) begin
      g.parent   = '0;
      g.child    = '0;
      g.is_right = 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    graft_t g;
    graft_t exp_g;
    bit     bad;
    if (rst) begin
      expected_grafts.delete();
      last_label = '0;
      want_root  = 1'b1;
      depth      = 0;
      for (int i = 0; i <= MAX_NODES; i++) left_child[LB_IDX_W'(i)] = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_grafts.size() == 0) begin
          $error("graft transaction with nothing expected: tdata %h tuser %b tlast %b",
                 m_tdata, m_tuser, m_tlast);
          fail_count <= fail_count + 1;
        end else begin
          exp_g = expected_grafts.pop_front();
          bad   = 1'b0;
          if (m_tdata[6:0] !== exp_g.parent) begin
            $error("parent: expected %0d, got %0d", exp_g.parent, m_tdata[6:0]);
            bad = 1'b1;
          end
          if (m_tdata[13:7] !== exp_g.child) begin
            $error("child: expected %0d, got %0d", exp_g.child, m_tdata[13:7]);
            bad = 1'b1;
          end
          if (m_tdata[14] !== exp_g.is_right) begin
            $error("is_right: expected %0d, got %0d", exp_g.is_right, m_tdata[14]);
            bad = 1'b1;
          end
          if (m_tuser !== exp_g.error) begin
            $error("error: expected %0d, got %0d", exp_g.error, m_tuser);
            bad = 1'b1;
          end
          if (m_tlast !== exp_g.seq_end) begin
            $error("seq_end: expected %0d, got %0d", exp_g.seq_end, m_tlast);
            bad = 1'b1;
          end
          if (bad) fail_count <= fail_count + 1;
        end
      end
      if (s_tvalid && s_tready) begin
        if (rebuild_step(s_tdata[iptr_pkg::LABEL_W-1:0], s_tlast, g)) begin
          expected_grafts.push_back(g);
        end
      end
    end
    pending <= expected_grafts.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 250;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [iptr_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [iptr_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;

  int                            fail_count;
  int                            pending;
  int                            send_idle_pct = 0;
  int                            recv_stall_pct = 0;
  int                            labels_sent = 0;
  int                            quiet_cycles = 0;
  logic [iptr_pkg::LABEL_W-1:0]  label_buf[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  inorder_preorder_tree_rebuild_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  tree_graft_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_label(input logic [iptr_pkg::LABEL_W-1:0] lbl, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, lbl};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    labels_sent++;
  endtask

  // Send the buffered labels as one sequence, tlast on the final one.
  task automatic send_buf();
    for (int i = 0; i < label_buf.size(); i++) begin
      send_label(label_buf[i], i == label_buf.size() - 1);
    end
    label_buf.delete();
  endtask

  // Preorder of a random tree whose inorder labels span lo..hi.
  task automatic add_subtree(input int lo, input int hi);
    int root;
    if (lo > hi) return;
    root = $urandom_range(hi, lo);
    label_buf.push_back(root[iptr_pkg::LABEL_W-1:0]);
    add_subtree(lo, root - 1);
    add_subtree(root + 1, hi);
  endtask

  task automatic add_random_tree();
    int lo;
    int span;
    if ($urandom_range(99) < 5) begin
      lo   = 0;
      span = iptr_pkg::LABEL_N;
    end else begin
      span = $urandom_range(16, 1);
      lo   = $urandom_range(iptr_pkg::LABEL_N - span);
    end
    add_subtree(lo, lo + span - 1);
  endtask

  // Descending runs by two push one label each; enough runs overflow the stack.
  task automatic add_deep_stack();
    int floor_lbl;
    label_buf.push_back(7'd127);
    for (int run = 0; run < 4; run++) begin
      floor_lbl = 2 * $urandom_range(7) + 1;
      for (int l = (run == 0) ? 125 : 127; l >= floor_lbl; l -= 2) label_buf.push_back(l[6:0]);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    int target;
    int kind;
    int pos;
    int n;
    idle_by_phase  = '{0, 45, 0, 22};
    stall_by_phase = '{0, 0, 45, 22};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-node tree
    send_label(7'd127, 1'b1);
    // repeated label empties the stack, the next pops an empty stack
    label_buf.push_back(7'd2); label_buf.push_back(7'd1);
    label_buf.push_back(7'd1); label_buf.push_back(7'd1);
    send_buf();
    // balanced tree with left and right grafts down to label 0
    label_buf.push_back(7'd3); label_buf.push_back(7'd1); label_buf.push_back(7'd0);
    label_buf.push_back(7'd2); label_buf.push_back(7'd5); label_buf.push_back(7'd4);
    label_buf.push_back(7'd6);
    send_buf();
    // top label has only the virtual successor
    label_buf.push_back(7'd126); label_buf.push_back(7'd127);
    send_buf();
    // root directly after a root-only sequence, then a left chain
    send_label(7'd64, 1'b1);
    label_buf.push_back(7'd85); label_buf.push_back(7'd42); label_buf.push_back(7'd21);
    label_buf.push_back(7'd10); label_buf.push_back(7'd0);
    send_buf();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      target         = labels_sent + PHASE_ITEMS;
      if (ph == 0) begin
        add_deep_stack();
        send_buf();
      end
      while (labels_sent < target) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          add_random_tree();
          send_buf();
        end else if (kind < 85) begin
          add_random_tree();
          pos = $urandom_range(label_buf.size() - 1);
          label_buf[pos] = iptr_pkg::LABEL_W'($urandom_range(iptr_pkg::LABEL_N - 1));
          if ($urandom_range(1) && label_buf.size() > 1) begin
            n = $urandom_range(label_buf.size() - 1, 1);
            while (label_buf.size() > n) void'(label_buf.pop_back());
          end
          send_buf();
        end else if (kind < 87) begin
          add_deep_stack();
          send_buf();
        end else begin
          n = $urandom_range(12, 1);
          repeat (n) begin
            send_label(iptr_pkg::LABEL_W'($urandom_range(iptr_pkg::LABEL_N - 1)),
                       $urandom_range(7) == 0);
          end
        end
      end
      // hold off until the block has delivered everything
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/iptr_pkg.sv
rtl/iptr_left_bits.sv
rtl/iptr_stack.sv
rtl/inorder_preorder_tree_rebuild_top.sv
verif/tree_graft_checker.sv
verif/tb_top.sv
